>>> rtl/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg: integer square root shared definitions
// Widths, constants and the stage record passed between the root cells.
// ----------------------------------------------------------------------------
package isr_pkg;

   localparam int VALUE_BITS = 32;
   localparam int ROOT_BITS  = VALUE_BITS / 2 + 1;
   localparam int DIGITS     = (VALUE_BITS + 1) / 2;
   localparam int PAD_BITS   = 2 * DIGITS;
   localparam int REM_BITS   = DIGITS + 1;

   localparam logic signed [ROOT_BITS-1:0] ROOT_NEGATIVE = '1;

   typedef struct packed {
      logic                negative;
      logic [PAD_BITS-1:0] radicand;
      logic [REM_BITS-1:0] remainder;
      logic [DIGITS-1:0]   root;
   } stage_type;

endpackage

>>> rtl/isr_if.sv
// ----------------------------------------------------------------------------
// isr_req_if / isr_rsp_if: valid-ready channels of the square root block
// One beat moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface isr_req_if;
   import isr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface isr_rsp_if;
   import isr_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [ROOT_BITS-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

>>> rtl/integer_square_root_floor.sv
// ----------------------------------------------------------------------------
// integer_square_root_floor: floor square root of a signed integer
// A beat is registered by the first root cell at the accepting edge, passes
// through each later cell in turn and then through the output register to
// become the result beat. A new beat is taken every cycle, so throughput is
// one item per cycle while the result side keeps up.
// Synchronous reset clears the valid bits of the cells and the output.
// ----------------------------------------------------------------------------
module integer_square_root_floor (
   input logic       clock,
   input logic       reset,
   isr_req_if.sink   req,
   isr_rsp_if.source rsp
);
   import isr_pkg::*;

   logic                        advance;
   logic                        chain_valid [0:DIGITS];
   stage_type                   chain_stage [0:DIGITS];
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic signed [ROOT_BITS-1:0] out_root_ff;
   logic signed [ROOT_BITS-1:0] out_root_in;

   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   assign chain_valid[0] = req.valid;
   assign chain_stage[0] = '{
      negative:  req.value[VALUE_BITS-1],
      radicand:  PAD_BITS'(unsigned'(req.value)),
      remainder: '0,
      root:      '0
   };

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      isr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (chain_valid[i]),
         .up_stage (chain_stage[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_stage (chain_stage[i+1])
      );
   end

   always_comb begin
      out_valid_in = chain_valid[DIGITS];
      if (chain_stage[DIGITS].negative) begin
         out_root_in = ROOT_NEGATIVE;
      end else begin
         out_root_in = ROOT_BITS'({1'b0, chain_stage[DIGITS].root});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_root_ff <= out_root_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.root  = out_root_ff;

endmodule

>>> rtl/isr_cell.sv
// ----------------------------------------------------------------------------
// isr_cell: one digit of the restoring square root
// Takes the next two radicand bits, settles one root bit and registers the
// result for the next cell.
// ----------------------------------------------------------------------------
module isr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  isr_pkg::stage_type up_stage,
   output logic               dn_valid,
   output isr_pkg::stage_type dn_stage
);
   import isr_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   stage_type           stage_ff;
   stage_type           stage_in;
   logic [REM_BITS+1:0] shifted;
   logic [REM_BITS+1:0] trial;
   logic [REM_BITS+1:0] diff;
   logic                take;

   always_comb begin
      shifted = {up_stage.remainder, up_stage.radicand[PAD_BITS-1 -: 2]};
      trial   = {1'b0, up_stage.root, 2'b01};
      diff    = shifted - trial;
      take    = (shifted >= trial);

      stage_in.negative = up_stage.negative;
      stage_in.radicand = {up_stage.radicand[PAD_BITS-3:0], 2'b00};
      stage_in.remainder = take ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
      stage_in.root = {up_stage.root[DIGITS-2:0], take};
      valid_in = up_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

>>> rtl/isr_checker.sv
// ----------------------------------------------------------------------------
// isr_checker: port-level checks of the square root block
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module isr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [isr_pkg::VALUE_BITS-1:0] req_value,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [isr_pkg::ROOT_BITS-1:0]  rsp_root
);
   import isr_pkg::*;

   // A stalled result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root))
      else $error("rsp beat changed while stalled");

   // A result is either minus one or a non-negative root.
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_root == ROOT_NEGATIVE) || !rsp_root[ROOT_BITS-1])
      else $error("rsp root out of range");

   // The input is never held off while the result side is draining.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req stalled while rsp ready");

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // A request beat that waits keeps its value.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_value))
      else $error("req beat changed while stalled");

endmodule

bind integer_square_root_floor isr_checker u_isr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_value (req.value),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_root  (rsp.root)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for integer_square_root_floor
// A table of directed values (signs, small values, perfect squares and the
// largest inputs) is followed by random values that lean toward the edges of
// perfect squares. Each accepted beat is checked against the typed table root
// or a floor root predictor. Both sides idle at random, with calm stretches.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isr_pkg::*;

   localparam int SMALL_LIMIT   = 5;
   localparam int RANDOM_VALUES = 1400;
   localparam int CHUNK_VALUES  = 100;
   localparam int MAX_IDLE      = 16;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         typed;
      logic signed [ROOT_BITS-1:0]  root;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   isr_req_if req_if ();
   isr_rsp_if rsp_if ();

   integer_square_root_floor u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   logic signed [ROOT_BITS-1:0] pending_roots[$];
   logic signed [ROOT_BITS-1:0] expected_roots[$];
   logic signed [ROOT_BITS-1:0] oldest_root;
   int unsigned                 failures = 0;
   logic                        calm = 1'b0;

   directed_row_type directed_rows [20] = '{
      '{32'sd0,           1'b1, 17'sd0},
      '{32'sd1,           1'b1, 17'sd1},
      '{32'sd2,           1'b1, 17'sd1},
      '{32'sd3,           1'b1, 17'sd1},
      '{32'sd4,           1'b1, 17'sd2},
      '{32'sd5,           1'b1, 17'sd2},
      '{32'sd6,           1'b0, 17'sd0},
      '{32'sd8,           1'b0, 17'sd0},
      '{32'sd9,           1'b0, 17'sd0},
      '{-32'sd1,          1'b1, -17'sd1},
      '{32'sh8000_0000,   1'b1, -17'sd1},
      '{32'sh7fff_ffff,   1'b1, 17'sd46340},
      '{32'sd2147395600,  1'b1, 17'sd46340},
      '{32'sd2147395599,  1'b0, 17'sd0},
      '{32'sd65536,       1'b1, 17'sd256},
      '{32'sd65535,       1'b0, 17'sd0},
      '{32'sh5555_5555,   1'b0, 17'sd0},
      '{32'shaaaa_aaaa,   1'b1, -17'sd1},
      '{32'sh4000_0000,   1'b1, 17'sd32768},
      '{32'sh3fff_ffff,   1'b0, 17'sd0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [ROOT_BITS-1:0] floor_sqrt(
      input logic signed [VALUE_BITS-1:0] value
   );
      logic [63:0] magnitude;
      logic [63:0] partial;
      logic [63:0] candidate;
      magnitude = {32'd0, value};
      partial   = '0;
      if (value < 0) return ROOT_NEGATIVE;
      if (magnitude <= 1) return magnitude[ROOT_BITS-1:0];
      if (magnitude <= SMALL_LIMIT) return magnitude[ROOT_BITS-1:0] / 2;
      for (int b = VALUE_BITS / 2 - 1; b >= 0; b--) begin
         candidate = partial | (64'd1 << b);
         if (candidate * candidate <= magnitude) partial = candidate;
      end
      return partial[ROOT_BITS-1:0];
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      logic [31:0] root;
      logic [63:0] square;
      case ($urandom_range(0, 9))
         0: return $urandom | 32'h8000_0000;
         1: return $urandom_range(0, 64);
         2, 3: begin
            root   = $urandom_range(0, 46340);
            square = root * root + $urandom_range(0, 2);
            return square[31:0] - 32'd1;
         end
         4, 5: return $urandom >> $urandom_range(1, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned idle_cycles();
      if (calm) return 0;
      return $urandom_range(0, MAX_IDLE);
   endfunction

   task automatic send_value(
      input logic signed [VALUE_BITS-1:0] value,
      input logic signed [ROOT_BITS-1:0]  root
   );
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= value;
      pending_roots.push_back(root);
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_roots();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_roots.size() != 0 || expected_roots.size() != 0);
   endtask

   // Results are checked before the beat taken at the same edge is queued.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_roots.size() == 0) begin
               $error("root: expected none, actual %0d", rsp_if.root);
               failures++;
            end else begin
               oldest_root = expected_roots.pop_front();
               if (rsp_if.root !== oldest_root) begin
                  $error("root: expected %0d, actual %0d", oldest_root, rsp_if.root);
                  failures++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_roots.push_back(pending_roots.pop_front());
         end
      end
   end

   initial begin
      int unsigned stall;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      logic signed [VALUE_BITS-1:0] value;
      req_if.valid = 1'b0;
      req_if.value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            send_value(directed_rows[i].value, directed_rows[i].root);
         end else begin
            send_value(directed_rows[i].value, floor_sqrt(directed_rows[i].value));
         end
      end
      drain_roots();

      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n % CHUNK_VALUES == 0) calm = (n / CHUNK_VALUES) % 3 == 2;
         if (n == RANDOM_VALUES / 2) drain_roots();
         value = random_value();
         send_value(value, floor_sqrt(value));
      end

      drain_roots();
      repeat (DIGITS + 8) @(posedge clock);
      if (failures == 0) begin
         $display("integer_square_root_floor regression: pass");
      end else begin
         $display("integer_square_root_floor regression: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("integer_square_root_floor regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/isr_pkg.sv
rtl/isr_if.sv
rtl/isr_cell.sv
rtl/integer_square_root_floor.sv
rtl/isr_checker.sv
test/testbench.sv
